FILE: rtl/trq_pkg.sv
// Package for the thread ready queue with ID allocator.
// Holds sizes, operation and status codes, the FSM state type and shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trq_pkg;

  localparam int MaxThreads = 64;
  localparam int IdW        = $clog2(MaxThreads);
  localparam int CntW       = $clog2(MaxThreads + 1);
  localparam int GrpW       = 8;
  localparam int GrpIdxW    = $clog2(GrpW);
  localparam int NumGrp     = (MaxThreads + GrpW - 1) / GrpW;

  localparam int OpW     = 2;
  localparam int TgtW    = 6;
  localparam int RidW    = 6;
  localparam int StatW   = 2;
  localparam int QcntW   = 7;

  typedef enum logic [OpW-1:0] {
    OP_ADD      = 2'd0,
    OP_REM_HEAD = 2'd1,
    OP_REM_ID   = 2'd2
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_NOMORE  = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic           found;
    logic [IdW-1:0] id;
  } free_t;

  typedef struct packed {
    logic ready;
    logic rd_en;
    logic done;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/trq_link_ram.sv
// Link memory: one write port, one read port with registered read data.
// Depends on trq_pkg for depth and entry width.
`timescale 1ns / 1ps
`default_nettype none

module trq_link_ram (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [trq_pkg::IdW-1:0] waddr_i,
  input  wire logic [trq_pkg::IdW-1:0] wdata_i,
  input  wire logic                    re_i,
  input  wire logic [trq_pkg::IdW-1:0] raddr_i,
  output      logic [trq_pkg::IdW-1:0] rdata_o
);
  import trq_pkg::*;

  logic [IdW-1:0] mem_q [MaxThreads];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/trq_free_search.sv
// Lowest-free-ID search: registered per-group stage, then a priority pick over groups.
// Depends on trq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trq_free_search (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [trq_pkg::MaxThreads-1:0] in_use_i,
  output      trq_pkg::free_t                 free_o
);
  import trq_pkg::*;

  logic [NumGrp*GrpW-1:0] padded;
  logic [NumGrp-1:0]      grp_any_d, grp_any_q;
  logic [GrpIdxW-1:0]     grp_idx_d [NumGrp];
  logic [GrpIdxW-1:0]     grp_idx_q [NumGrp];

  always_comb begin
    padded = '1;
    padded[MaxThreads-1:0] = in_use_i;
    for (int g = 0; g < NumGrp; g++) begin
      grp_any_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int b = GrpW - 1; b >= 0; b--) begin
        if (!padded[g*GrpW + b]) begin
          grp_any_d[g] = 1'b1;
          grp_idx_d[g] = GrpIdxW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_any_q <= '0;
    end else begin
      grp_any_q <= grp_any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_idx_q[g] <= grp_idx_d[g];
    end
  end

  always_comb begin
    free_o = '0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        free_o.found = 1'b1;
        free_o.id    = IdW'(g * GrpW + int'(grp_idx_q[g]));
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/thread_ready_queue_with_id_alloc_core.sv
// Thread ready queue with lowest-free ID allocator; top level and sequencer.
// Depends on trq_pkg, trq_link_ram and trq_free_search.
// The result is registered when the request completes in S_EXEC; S_EXEC waits while
// the previous result is still held in the output register.
// A new request is accepted only in S_IDLE, after the previous one has read the
// link memories and written back the neighbor links.
// Reset: ID 0 alone in the queue; link memories are not cleared, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module thread_ready_queue_with_id_alloc_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic [trq_pkg::OpW-1:0]   operation_i,
  input  wire logic [trq_pkg::TgtW-1:0]  target_id_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic [trq_pkg::RidW-1:0]  result_id_o,
  output      logic [trq_pkg::StatW-1:0] status_o,
  output      logic [trq_pkg::QcntW-1:0] queue_count_o
);
  import trq_pkg::*;

  state_e                state_q, state_d;
  ctrl_t                 ctrl;
  free_t                 free;

  logic [MaxThreads-1:0] in_use_q, in_use_d;
  logic [IdW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [OpW-1:0]        op_q;
  logic [IdW-1:0]        tgt_q;
  logic                  tgt_ok_q;

  logic [IdW-1:0]        nxt_rd, prv_rd;
  logic [IdW-1:0]        rd_addr;
  logic                  nxt_we, prv_we;
  logic [IdW-1:0]        nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;

  logic                  out_valid_q;
  logic [IdW-1:0]        rid_d, rid_q;
  status_e               stat_d, stat_q;
  logic [QcntW-1:0]      qcnt_q;

  logic                  do_unlink;
  logic [IdW-1:0]        ul_id;

  logic                  accept;
  assign accept = in_valid_i && ctrl.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      S_IDLE: begin
        ctrl.ready = 1'b1;
        ctrl.rd_en = in_valid_i;
      end
      S_EXEC: begin
        ctrl.done = !out_valid_q || out_ready_i;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign rd_addr = (operation_i == OP_REM_HEAD) ? head_q : IdW'(target_id_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      tgt_q    <= IdW'(target_id_i);
      tgt_ok_q <= (int'(target_id_i) < MaxThreads);
    end
  end

  trq_link_ram u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (ctrl.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (nxt_rd)
  );

  trq_link_ram u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .re_i    (ctrl.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (prv_rd)
  );

  trq_free_search u_free (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_use_i (in_use_q),
    .free_o   (free)
  );

  // execute: links were read at accept, write-back happens at the done edge
  always_comb begin
    in_use_d  = in_use_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    nxt_we    = 1'b0;
    prv_we    = 1'b0;
    nxt_waddr = tail_q;
    nxt_wdata = free.id;
    prv_waddr = free.id;
    prv_wdata = tail_q;
    rid_d     = '0;
    stat_d    = ST_INVALID;
    do_unlink = 1'b0;
    ul_id     = tgt_q;

    case (op_e'(op_q))
      OP_ADD: begin
        if (!free.found) begin
          stat_d = ST_NOMORE;
        end else begin
          stat_d = ST_OK;
          rid_d  = free.id;
          in_use_d[free.id] = 1'b1;
          count_d = count_q + CntW'(1);
          tail_d  = free.id;
          if (count_q == '0) begin
            head_d = free.id;
          end else begin
            nxt_we = ctrl.done;
            prv_we = ctrl.done;
          end
        end
      end
      OP_REM_HEAD: begin
        if (count_q != '0) begin
          do_unlink = 1'b1;
          ul_id     = head_q;
        end
      end
      OP_REM_ID: begin
        if (count_q != '0 && tgt_ok_q && in_use_q[tgt_q]) begin
          do_unlink = 1'b1;
          ul_id     = tgt_q;
        end
      end
      default: stat_d = ST_INVALID;
    endcase

    if (do_unlink) begin
      stat_d = ST_OK;
      rid_d  = ul_id;
      in_use_d[ul_id] = 1'b0;
      count_d = count_q - CntW'(1);
      if (count_q <= CntW'(1)) begin
        head_d = '0;
        tail_d = '0;
      end else if (ul_id == head_q) begin
        head_d = nxt_rd;
      end else if (ul_id == tail_q) begin
        tail_d = prv_rd;
      end else begin
        nxt_we    = ctrl.done;
        nxt_waddr = prv_rd;
        nxt_wdata = nxt_rd;
        prv_we    = ctrl.done;
        prv_waddr = nxt_rd;
        prv_wdata = prv_rd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= MaxThreads'(1);
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= CntW'(1);
    end else if (ctrl.done) begin
      in_use_q <= in_use_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      rid_q  <= rid_d;
      stat_q <= stat_d;
      qcnt_q <= QcntW'(count_d);
    end
  end

  assign in_ready_o    = ctrl.ready;
  assign out_valid_o   = out_valid_q;
  assign result_id_o   = RidW'(rid_q);
  assign status_o      = stat_q;
  assign queue_count_o = qcnt_q;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the thread ready queue with ID allocator.
// A clocked driver and monitor are checked against a queue predictor kept in the bench.
// Depends on trq_pkg and thread_ready_queue_with_id_alloc_core.
`timescale 1ns / 1ps

module testbench;
  import trq_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int StallLimit = 2000;
  localparam int PhaseItems = 488;

  typedef struct {
    logic [OpW-1:0]  op;
    logic [TgtW-1:0] tgt;
  } req_t;

  typedef struct {
    logic [RidW-1:0]  rid;
    status_e          status;
    logic [QcntW-1:0] qcnt;
  } qres_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OpW-1:0]        operation = OP_ADD;
  logic [TgtW-1:0]       target_id = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RidW-1:0]       result_id;
  logic [StatW-1:0]      status;
  logic [QcntW-1:0]      queue_count;

  req_t  pend_reqs[$];
  qres_t exp_results[$];
  int    err_cnt = 0;
  int    snd_idle_pct = 0;
  int    rcv_stall_pct = 0;
  int    stall_cycles = 0;
  int    gen_left;

  // Predictor state
  logic            q_busy[MaxThreads];
  logic [IdW-1:0]  q_next[MaxThreads];
  logic [IdW-1:0]  q_prev[MaxThreads];
  logic [IdW-1:0]  q_head;
  logic [IdW-1:0]  q_tail;
  int              q_cnt;

  // Stimulus-side view of the queue order, used to pick queued targets
  int unsigned     gen_order[$];
  bit [MaxThreads-1:0] gen_busy;

  thread_ready_queue_with_id_alloc_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .operation_i   (operation),
    .target_id_i   (target_id),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_id_o   (result_id),
    .status_o      (status),
    .queue_count_o (queue_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void ready_q_reset();
    for (int i = 0; i < MaxThreads; i++) begin
      q_busy[i] = 1'b0;
      q_next[i] = '0;
      q_prev[i] = '0;
    end
    q_busy[0] = 1'b1;
    q_head = '0;
    q_tail = '0;
    q_cnt = 1;
  endfunction

  function automatic void ready_q_unlink(logic [IdW-1:0] id);
    logic [IdW-1:0] p;
    logic [IdW-1:0] n;
    p = q_prev[id];
    n = q_next[id];
    if (q_cnt <= 1) begin
      q_head = '0;
      q_tail = '0;
    end else if (id == q_head) begin
      q_head = n;
    end else if (id == q_tail) begin
      q_tail = p;
    end else begin
      q_next[p] = n;
      q_prev[n] = p;
    end
    q_busy[id] = 1'b0;
    if (q_cnt > 0) q_cnt--;
  endfunction

  function automatic qres_t ready_q_predict(logic [OpW-1:0] op, logic [TgtW-1:0] tgt);
    qres_t r;
    int    fid;
    r.rid = '0;
    r.status = ST_INVALID;
    if (op == OP_ADD) begin
      fid = -1;
      for (int i = MaxThreads - 1; i >= 0; i--) begin
        if (!q_busy[i]) fid = i;
      end
      if (fid < 0) begin
        r.status = ST_NOMORE;
      end else begin
        q_busy[fid] = 1'b1;
        if (q_cnt == 0) begin
          q_head = IdW'(fid);
        end else begin
          q_prev[fid] = q_tail;
          q_next[q_tail] = IdW'(fid);
        end
        q_tail = IdW'(fid);
        q_cnt++;
        r.rid = RidW'(fid);
        r.status = ST_OK;
      end
    end else if (op == OP_REM_HEAD) begin
      if (q_cnt != 0) begin
        r.rid = RidW'(q_head);
        ready_q_unlink(q_head);
        r.status = ST_OK;
      end
    end else if (op == OP_REM_ID) begin
      if (q_cnt != 0 && int'(tgt) < MaxThreads && q_busy[tgt]) begin
        r.rid = RidW'(tgt);
        ready_q_unlink(IdW'(tgt));
        r.status = ST_OK;
      end
    end
    r.qcnt = QcntW'(q_cnt);
    return r;
  endfunction

  task automatic push_req(logic [OpW-1:0] op, logic [TgtW-1:0] tgt);
    req_t rq;
    int   fid;
    rq.op = op;
    rq.tgt = tgt;
    pend_reqs.push_back(rq);
    gen_left--;
    if (op == OP_ADD) begin
      fid = -1;
      for (int i = MaxThreads - 1; i >= 0; i--) begin
        if (!gen_busy[i]) fid = i;
      end
      if (fid >= 0) begin
        gen_busy[fid] = 1'b1;
        gen_order.push_back(fid);
      end
    end else if (op == OP_REM_HEAD) begin
      if (gen_order.size() != 0) gen_busy[gen_order.pop_front()] = 1'b0;
    end else if (op == OP_REM_ID && gen_busy[tgt]) begin
      gen_busy[tgt] = 1'b0;
      for (int i = 0; i < gen_order.size(); i++) begin
        if (gen_order[i] == tgt) begin
          gen_order.delete(i);
          break;
        end
      end
    end
  endtask

  function automatic logic [TgtW-1:0] rand_tgt();
    return TgtW'($urandom_range(MaxThreads - 1));
  endfunction

  function automatic logic [TgtW-1:0] queued_tgt();
    if (gen_order.size() == 0) return rand_tgt();
    return TgtW'(gen_order[$urandom_range(gen_order.size() - 1)]);
  endfunction

  task automatic gen_burst();
    int kind;
    int n;
    int w;
    kind = $urandom_range(99);
    if (kind < 15) begin
      while (gen_order.size() < MaxThreads) push_req(OP_ADD, rand_tgt());
      n = $urandom_range(4, 1);
      repeat (n) push_req(OP_ADD, rand_tgt());
    end else if (kind < 30) begin
      while (gen_order.size() != 0) begin
        if ($urandom_range(1)) push_req(OP_REM_HEAD, rand_tgt());
        else push_req(OP_REM_ID, queued_tgt());
      end
      n = $urandom_range(3, 1);
      repeat (n) push_req($urandom_range(1) ? OP_REM_HEAD : OP_REM_ID, rand_tgt());
    end else begin
      n = $urandom_range(40, 20);
      repeat (n) begin
        w = $urandom_range(99);
        if (w < 40) push_req(OP_ADD, rand_tgt());
        else if (w < 60) push_req(OP_REM_HEAD, rand_tgt());
        else if (w < 85) push_req(OP_REM_ID, queued_tgt());
        else if (w < 95) push_req(OP_REM_ID, rand_tgt());
        else push_req(OpUnused, rand_tgt());
      end
    end
  endtask

  task automatic gen_directed();
    push_req(OP_REM_ID, 6'd0);
    push_req(OP_REM_HEAD, 6'd63);
    push_req(OP_REM_ID, 6'd5);
    push_req(OpUnused, 6'd0);
    push_req(OP_ADD, 6'd63);
    push_req(OP_ADD, 6'd0);
    push_req(OP_ADD, 6'd42);
    push_req(OP_ADD, 6'd21);
    push_req(OP_REM_ID, 6'd2);
    push_req(OP_REM_ID, 6'd3);
    push_req(OP_REM_ID, 6'd63);
    push_req(OP_REM_ID, 6'd2);
    push_req(OP_REM_HEAD, 6'd0);
    push_req(OP_ADD, 6'd0);
    push_req(OP_REM_ID, 6'd1);
    push_req(OpUnused, 6'd63);
    push_req(OP_REM_HEAD, 6'd0);
    push_req(OP_REM_HEAD, 6'd0);
    push_req(OP_REM_ID, 6'd0);
  endtask

  // Driver: requests from pend_reqs, prediction at acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    req_t nxt;
    logic can_load;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      operation <= OP_ADD;
      target_id <= '0;
    end else begin
      if (in_valid && in_ready) begin
        exp_results.push_back(ready_q_predict(operation, target_id));
      end
      can_load = !in_valid || in_ready;
      if (can_load && pend_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        nxt = pend_reqs.pop_front();
        in_valid <= 1'b1;
        operation <= nxt.op;
        target_id <= nxt.tgt;
      end else if (can_load) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    qres_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      if (out_valid && out_ready) begin
        if (exp_results.size() == 0) begin
          $error("unexpected result: result_id %0d status %0d queue_count %0d",
                 result_id, status, queue_count);
          err_cnt++;
        end else begin
          want = exp_results.pop_front();
          if (result_id !== want.rid) begin
            $error("result_id mismatch: expected %0d, actual %0d", want.rid, result_id);
            err_cnt++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            err_cnt++;
          end
          if (queue_count !== want.qcnt) begin
            $error("queue_count mismatch: expected %0d, actual %0d", want.qcnt, queue_count);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: cycles without any handshake while work is outstanding
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (pend_reqs.size() == 0 && exp_results.size() == 0 && !in_valid)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    ready_q_reset();
    gen_busy = '0;
    gen_busy[0] = 1'b1;
    gen_order.push_back(0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk_i);
      case (ph)
        0: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          snd_idle_pct = 69;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 69;
        end
        default: begin
          snd_idle_pct = 17;
          rcv_stall_pct = 17;
        end
      endcase
      gen_left = PhaseItems;
      if (ph == 0) gen_directed();
      while (gen_left > 0) gen_burst();
      while (pend_reqs.size() != 0) @(negedge clk_i);
    end
    while (exp_results.size() != 0 || in_valid) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
